FILE: hdl/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// Shared constants, types and the arctangent table for the rotation matrix
// unit.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int OUT_BITS    = 16;
    localparam int ITERS       = 30;
    localparam int IDX_BITS    = $clog2(ITERS);
    localparam int CW          = 34;              // Q30 datapath width
    localparam int PW          = 2 * CW;          // Q60 product width
    localparam int Q           = 30;
    localparam int SHIFT       = 2 * Q - FRAC_BITS;
    localparam int MAT_STAGES  = 4;
    localparam int DEPTH       = ITERS + 2 + MAT_STAGES;

    localparam logic signed [CW-1:0] CORDIC_K = CW'(652032874);

    typedef logic signed [CW-1:0]       q30_t;
    typedef logic signed [PW-1:0]       q60_t;
    typedef logic signed [OUT_BITS-1:0] entry_t;

    typedef struct packed {
        q30_t x;
        q30_t y;
        q30_t z;
        logic flip;
    } cordic_t;

    function automatic q30_t atan_turns(input logic [IDX_BITS-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return q30_t'({2'b00, v});
    endfunction

endpackage

FILE: hdl/euler_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_unit
// Roll, pitch and yaw binary angles in, Rz*Ry*Rx rotation matrix out.
// ----------------------------------------------------------------------------
// One angle set is taken per clock and one matrix word leaves per clock.
// The pipeline is a fold register, a chain of 30 CORDIC cells, a sign
// register and four product stages; the output register of the last stage
// holds the word. The whole pipeline advances whenever the output register
// is empty or being taken, so a stall on the master side holds everything.
module euler_to_rotation_matrix_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // roll, pitch, yaw
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);
    import erm_pkg::*;

    logic             ce;
    logic [DEPTH-1:0] valid_reg, valid_next;
    q30_t             sr, cr, sp, cp, sy, cy;
    entry_t           m [9];

    assign ce       = !valid_reg[DEPTH-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = valid_reg[DEPTH-1];

    always_comb begin
        valid_next = {valid_reg[DEPTH-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
    end

    erm_sincos u_roll (
        .aclk (aclk), .ce (ce), .angle (s_tdata[15:0]),  .sin_q (sr), .cos_q (cr)
    );
    erm_sincos u_pitch (
        .aclk (aclk), .ce (ce), .angle (s_tdata[31:16]), .sin_q (sp), .cos_q (cp)
    );
    erm_sincos u_yaw (
        .aclk (aclk), .ce (ce), .angle (s_tdata[47:32]), .sin_q (sy), .cos_q (cy)
    );

    erm_matrix u_matrix (
        .aclk (aclk), .ce (ce),
        .sr (sr), .cr (cr), .sp (sp), .cp (cp), .sy (sy), .cy (cy),
        .m (m)
    );

    assign m_tdata = {m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};

endmodule

FILE: hdl/erm_cordic_cell.sv
// ----------------------------------------------------------------------------
// erm_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module erm_cordic_cell (
    input  logic                            aclk,
    input  logic                            ce,
    input  logic [erm_pkg::IDX_BITS-1:0]    idx,
    input  erm_pkg::cordic_t                d_in,
    output erm_pkg::cordic_t                d_out
);
    import erm_pkg::*;

    cordic_t cell_reg, cell_next;
    q30_t    dx, dy, at;

    always_comb begin
        dx = d_in.y >>> idx;
        dy = d_in.x >>> idx;
        at = atan_turns(idx);
        cell_next = d_in;
        if (!d_in.z[CW-1]) begin
            cell_next.x = d_in.x - dx;
            cell_next.y = d_in.y + dy;
            cell_next.z = d_in.z - at;
        end else begin
            cell_next.x = d_in.x + dx;
            cell_next.y = d_in.y - dy;
            cell_next.z = d_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

FILE: hdl/erm_sincos.sv
// ----------------------------------------------------------------------------
// erm_sincos
// Quarter-turn fold, a chain of CORDIC cells and the final sign fix.
// ----------------------------------------------------------------------------
module erm_sincos (
    input  logic                            aclk,
    input  logic                            ce,
    input  logic [erm_pkg::ANGLE_BITS-1:0]  angle,
    output erm_pkg::q30_t                   sin_q,
    output erm_pkg::q30_t                   cos_q
);
    import erm_pkg::*;

    cordic_t     chain [ITERS+1];
    cordic_t     fold_next;
    logic [31:0] a;
    q30_t        sin_reg, cos_reg;

    always_comb begin
        a = {angle, {(32 - ANGLE_BITS){1'b0}}};
        fold_next.flip = a[31] ^ a[30];
        if (fold_next.flip) begin
            a[31] = ~a[31];
        end
        fold_next.x = CORDIC_K;
        fold_next.y = '0;
        fold_next.z = q30_t'(signed'(a));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            chain[0] <= fold_next;
        end
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_cell
        erm_cordic_cell u_cell (
            .aclk  (aclk),
            .ce    (ce),
            .idx   (IDX_BITS'(i)),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sin_reg <= chain[ITERS].flip ? -chain[ITERS].y : chain[ITERS].y;
            cos_reg <= chain[ITERS].flip ? -chain[ITERS].x : chain[ITERS].x;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

FILE: hdl/erm_matrix.sv
// ----------------------------------------------------------------------------
// erm_matrix
// Forms the nine matrix entries from the sines and cosines, four stages.
// ----------------------------------------------------------------------------
module erm_matrix (
    input  logic                    aclk,
    input  logic                    ce,
    input  erm_pkg::q30_t           sr,
    input  erm_pkg::q30_t           cr,
    input  erm_pkg::q30_t           sp,
    input  erm_pkg::q30_t           cp,
    input  erm_pkg::q30_t           sy,
    input  erm_pkg::q30_t           cy,
    output erm_pkg::entry_t         m [9]
);
    import erm_pkg::*;

    function automatic entry_t finish(input q60_t v);
        q60_t r;
        r = (v + (q60_t'(1) <<< (SHIFT - 1))) >>> SHIFT;
        if (r > q60_t'(1 << FRAC_BITS)) begin
            r = q60_t'(1 << FRAC_BITS);
        end else if (r < -q60_t'(1 << FRAC_BITS)) begin
            r = -q60_t'(1 << FRAC_BITS);
        end
        return r[OUT_BITS-1:0];
    endfunction

    // stage A
    q60_t a_cycp, a_sycp, a_cpsr, a_cpcr, a_sycr, a_sysr, a_cycr, a_cysr;
    q60_t a_cysp, a_sysp;
    q30_t a_sr, a_cr, a_sp;
    // stage B
    q60_t b_cycp, b_sycp, b_cpsr, b_cpcr, b_sycr, b_sysr, b_cycr, b_cysr;
    q30_t b_cysp, b_sysp, b_sr, b_cr, b_sp;
    // stage C
    q60_t c_cycp, c_sycp, c_cpsr, c_cpcr, c_sycr, c_sysr, c_cycr, c_cysr;
    q60_t c_t1, c_t2, c_t4, c_t5;
    q30_t c_sp;
    entry_t m_reg [9];
    q60_t   rnd_cysp, rnd_sysp;

    always_comb begin
        rnd_cysp = (a_cysp + (q60_t'(1) <<< (Q - 1))) >>> Q;
        rnd_sysp = (a_sysp + (q60_t'(1) <<< (Q - 1))) >>> Q;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_cycp <= PW'(cy) * PW'(cp);
            a_sycp <= PW'(sy) * PW'(cp);
            a_cpsr <= PW'(cp) * PW'(sr);
            a_cpcr <= PW'(cp) * PW'(cr);
            a_sycr <= PW'(sy) * PW'(cr);
            a_sysr <= PW'(sy) * PW'(sr);
            a_cycr <= PW'(cy) * PW'(cr);
            a_cysr <= PW'(cy) * PW'(sr);
            a_cysp <= PW'(cy) * PW'(sp);
            a_sysp <= PW'(sy) * PW'(sp);
            a_sr   <= sr;
            a_cr   <= cr;
            a_sp   <= sp;

            b_cycp <= a_cycp;  b_sycp <= a_sycp;
            b_cpsr <= a_cpsr;  b_cpcr <= a_cpcr;
            b_sycr <= a_sycr;  b_sysr <= a_sysr;
            b_cycr <= a_cycr;  b_cysr <= a_cysr;
            b_cysp <= rnd_cysp[CW-1:0];
            b_sysp <= rnd_sysp[CW-1:0];
            b_sr   <= a_sr;
            b_cr   <= a_cr;
            b_sp   <= a_sp;

            c_cycp <= b_cycp;  c_sycp <= b_sycp;
            c_cpsr <= b_cpsr;  c_cpcr <= b_cpcr;
            c_sycr <= b_sycr;  c_sysr <= b_sysr;
            c_cycr <= b_cycr;  c_cysr <= b_cysr;
            c_t1   <= PW'(b_cysp) * PW'(b_sr);
            c_t2   <= PW'(b_cysp) * PW'(b_cr);
            c_t4   <= PW'(b_sysp) * PW'(b_sr);
            c_t5   <= PW'(b_sysp) * PW'(b_cr);
            c_sp   <= b_sp;

            m_reg[0] <= finish(c_cycp);
            m_reg[1] <= finish(c_t1 - c_sycr);
            m_reg[2] <= finish(c_t2 + c_sysr);
            m_reg[3] <= finish(c_sycp);
            m_reg[4] <= finish(c_t4 + c_cycr);
            m_reg[5] <= finish(c_t5 - c_cysr);
            m_reg[6] <= finish(-(PW'(c_sp) <<< Q));
            m_reg[7] <= finish(c_cpsr);
            m_reg[8] <= finish(c_cpcr);
        end
    end

    assign m = m_reg;

endmodule
